/* src/sum_difference_coverage_scorer_macros.svh */
// assertion macros shared by the scorer rtl
`ifndef SUM_DIFFERENCE_COVERAGE_SCORER_MACROS_SVH
`define SUM_DIFFERENCE_COVERAGE_SCORER_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* src/sdcs_pkg.sv */
// shared constants and types of the sum/difference coverage scorer
package sdcs_pkg;

	localparam int ELEM_W        = 16;
	localparam int SCORE_W       = 15;
	localparam int VAL_W         = 18;
	localparam int WORD_W        = 64;
	localparam int BIT_W         = 6;
	localparam int MAX_ELEMS_DEF = 128;
	localparam int MAP_WORDS_DEF = 512;
	localparam logic [SCORE_W-1:0] SCORE_MAX = 15'h7FFF;

	typedef enum logic {
		MAP_MARK,
		MAP_SCAN
	} map_op_t;

	typedef struct packed {
		logic                     valid;
		map_op_t                  op;
		logic signed [VAL_W-1:0]  value;
	} map_req_t;

	typedef struct packed {
		logic                     ready;
		logic                     done;
		logic [SCORE_W-1:0]       score;
	} map_rsp_t;

endpackage

/* src/sdcs_if.sv */
// valid/ready channel interfaces for the scorer's input and result streams
interface sdcs_in_if;
	import sdcs_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] element;
	logic                     last;

	modport source (output valid, output element, output last, input ready);
	modport sink (input valid, input element, input last, output ready);
endinterface

interface sdcs_out_if;
	import sdcs_pkg::*;

	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] score;
	logic               overflowed;

	modport source (output valid, output score, output overflowed, input ready);
	modport sink (input valid, input score, input overflowed, output ready);
endinterface

/* src/sdcs_elem_store.sv */
// element store: one write port, one registered read port
module sdcs_elem_store #(
	parameter int MAX_ELEMS = sdcs_pkg::MAX_ELEMS_DEF
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [((MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1)-1:0] waddr,
	input  logic signed [sdcs_pkg::ELEM_W-1:0] wdata,
	input  logic [((MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1)-1:0] raddr,
	output logic signed [sdcs_pkg::ELEM_W-1:0] rdata
);
	import sdcs_pkg::*;

	logic signed [ELEM_W-1:0] mem [MAX_ELEMS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/sdcs_cov_map.sv */
// coverage map memory with mark read-modify-write, run-length scan and clear sweep
`include "sum_difference_coverage_scorer_macros.svh"

module sdcs_cov_map #(
	parameter int MAP_WORDS = sdcs_pkg::MAP_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sdcs_pkg::map_req_t req,
	output sdcs_pkg::map_rsp_t rsp
);
	import sdcs_pkg::*;

	localparam int WA_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int MapBits = MAP_WORDS * WORD_W;
	localparam int CntW    = $clog2(MapBits + 1);
	localparam int ScW     = (CntW > 16) ? CntW : 16;

	typedef enum logic [1:0] {
		M_CLEAR,
		M_IDLE,
		M_WR,
		M_SCAN
	} state_t;

	state_t             state_q;
	logic [WA_W-1:0]    addr_q;
	logic [BIT_W-1:0]   bit_q;
	logic               done_q;
	logic [SCORE_W-1:0] score_q;

	logic [WORD_W-1:0]  mem [MAP_WORDS];
	logic [WORD_W-1:0]  rd_q;

	logic               rd_en;
	logic [WA_W-1:0]    rd_addr;
	logic               wr_en;
	logic [WORD_W-1:0]  wr_data;

	logic               in_range;
	logic [WA_W-1:0]    v_word;
	logic [BIT_W-1:0]   v_bit;
	logic [WORD_W-1:0]  scan_word;
	logic               all_ones;
	logic               at_end;
	logic [BIT_W-1:0]   zero_pos;
	logic [ScW-1:0]     run_len;
	logic [SCORE_W-1:0] score_c;

	function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (!w[b]) begin
				r = BIT_W'(b);
			end
		end
		return r;
	endfunction

	assign in_range = !req.value[VAL_W-1] && (32'($unsigned(req.value)) < 32'(MapBits));
	assign v_word   = req.value[BIT_W+WA_W-1:BIT_W];
	assign v_bit    = req.value[BIT_W-1:0];

	// bit zero of the map sits outside the run, treat it as covered
	assign scan_word = rd_q | ((addr_q == '0) ? WORD_W'(1) : '0);
	assign all_ones  = &scan_word;
	assign at_end    = (addr_q == WA_W'(MAP_WORDS - 1));
	assign zero_pos  = first_zero(scan_word);
	assign run_len   = all_ones ? ScW'(MapBits - 1) : (ScW'({addr_q, zero_pos}) - ScW'(1));
	assign score_c   = (run_len > ScW'(SCORE_MAX)) ? SCORE_MAX : run_len[SCORE_W-1:0];

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_q;
		wr_en   = 1'b0;
		wr_data = '0;
		case (state_q)
			M_CLEAR: begin
				wr_en = 1'b1;
			end
			M_IDLE: begin
				if (req.valid && req.op == MAP_MARK && in_range) begin
					rd_en   = 1'b1;
					rd_addr = v_word;
				end else if (req.valid && req.op == MAP_SCAN) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			M_WR: begin
				wr_en   = 1'b1;
				wr_data = rd_q | (WORD_W'(1) << bit_q);
			end
			M_SCAN: begin
				if (all_ones && !at_end) begin
					rd_en   = 1'b1;
					rd_addr = addr_q + WA_W'(1);
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_CLEAR;
			addr_q  <= '0;
			bit_q   <= '0;
			done_q  <= 1'b0;
			score_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_CLEAR: begin
					if (at_end) begin
						addr_q  <= '0;
						state_q <= M_IDLE;
					end else begin
						addr_q <= addr_q + WA_W'(1);
					end
				end
				M_IDLE: begin
					if (req.valid && req.op == MAP_MARK && in_range) begin
						addr_q  <= v_word;
						bit_q   <= v_bit;
						state_q <= M_WR;
					end else if (req.valid && req.op == MAP_SCAN) begin
						addr_q  <= '0;
						state_q <= M_SCAN;
					end
				end
				M_WR: begin
					state_q <= M_IDLE;
				end
				M_SCAN: begin
					if (all_ones && !at_end) begin
						addr_q <= addr_q + WA_W'(1);
					end else begin
						done_q  <= 1'b1;
						score_q <= score_c;
						addr_q  <= '0;
						state_q <= M_CLEAR;
					end
				end
				default: begin
					state_q <= M_CLEAR;
				end
			endcase
		end
	end

	assign rsp.ready = (state_q == M_IDLE);
	assign rsp.done  = done_q;
	assign rsp.score = score_q;

	`ASSERT_IMPLIES(a_done_starts_clear, clk, arst_n, done_q, state_q == M_CLEAR)
	`ASSERT_IMPLIES(a_wr_after_mark, clk, arst_n, state_q == M_WR, $past(req.valid && rsp.ready && req.op == MAP_MARK))
	`ASSERT_NEXT(a_scan_ends_in_clear, clk, arst_n, state_q == M_SCAN, state_q == M_SCAN || state_q == M_CLEAR)

endmodule

/* src/sum_difference_coverage_scorer.sv */
// Sum/difference coverage scorer. Elements arrive one per transfer; each stored element is
// paired with every earlier one through a single shared adder/subtractor, and every mark is a
// read-modify-write on the single-port coverage map. An element arriving with n elements
// already stored makes 2n+3 marks (itself, its sum and difference with each stored element,
// its double and zero); marks that fall off the map are taken without a write, and a dropped
// element makes none. The closing element adds a run-length scan, after which the result is
// offered and the map is swept clear, during which the next element waits for its first mark.
// After reset the same clear sweep runs first. The result register frees the input side while
// a result waits to be taken; a further closing element waits in its scan step until then.
`include "sum_difference_coverage_scorer_macros.svh"

module sum_difference_coverage_scorer #(
	parameter int MAX_ELEMS = sdcs_pkg::MAX_ELEMS_DEF,
	parameter int MAP_WORDS = sdcs_pkg::MAP_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	sdcs_in_if.sink           items,
	sdcs_out_if.source        results
);
	import sdcs_pkg::*;

	localparam int AW    = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
	localparam int CNT_W = $clog2(MAX_ELEMS + 1);

	typedef enum logic [2:0] {
		T_IDLE,
		T_X,
		T_SUM,
		T_DIF,
		T_DBL,
		T_ZERO,
		T_SCAN,
		T_WAIT
	} state_t;

	state_t                   state_q;
	logic signed [ELEM_W-1:0] x_q;
	logic                     last_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         idx_q;
	logic                     overflow_q;
	logic                     out_valid_q;
	logic [SCORE_W-1:0]       score_q;
	logic                     ovf_out_q;

	map_req_t                 map_req;
	map_rsp_t                 map_rsp;
	logic                     map_acc;
	logic                     in_acc;

	logic signed [ELEM_W-1:0] e_rd;
	logic [CNT_W-1:0]         idx_inc;
	logic [CNT_W-1:0]         rd_idx;
	logic                     st_we;

	logic signed [VAL_W-1:0]  op_a;
	logic signed [VAL_W-1:0]  op_b;
	logic                     op_sub;

	assign in_acc  = items.valid && items.ready;
	assign map_acc = map_req.valid && map_rsp.ready;
	assign idx_inc = idx_q + CNT_W'(1);

	// fetch the next partner while the current difference is handed over
	assign rd_idx = (state_q == T_DIF && map_acc) ? idx_inc : idx_q;
	assign st_we  = (state_q == T_ZERO) && map_acc;

	sdcs_elem_store #(
		.MAX_ELEMS(MAX_ELEMS)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (count_q[AW-1:0]),
		.wdata (x_q),
		.raddr (rd_idx[AW-1:0]),
		.rdata (e_rd)
	);

	// shared adder/subtractor feeding every mark
	always_comb begin
		op_a   = (state_q == T_ZERO) ? '0 : VAL_W'(x_q);
		op_b   = '0;
		op_sub = 1'b0;
		case (state_q)
			T_SUM: begin
				op_b = VAL_W'(e_rd);
			end
			T_DIF: begin
				op_b   = VAL_W'(e_rd);
				op_sub = 1'b1;
			end
			T_DBL: begin
				op_b = VAL_W'(x_q);
			end
			default: begin
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		map_req.value = op_sub ? (op_a - op_b) : (op_a + op_b);
		map_req.op    = (state_q == T_SCAN) ? MAP_SCAN : MAP_MARK;
		case (state_q)
			T_X, T_SUM, T_DIF, T_DBL, T_ZERO: begin
				map_req.valid = 1'b1;
			end
			T_SCAN: begin
				map_req.valid = !out_valid_q;
			end
			default: begin
				map_req.valid = 1'b0;
			end
		endcase
	end

	sdcs_cov_map #(
		.MAP_WORDS(MAP_WORDS)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (map_req),
		.rsp    (map_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			x_q         <= '0;
			last_q      <= 1'b0;
			count_q     <= '0;
			idx_q       <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
			score_q     <= '0;
			ovf_out_q   <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (in_acc) begin
						x_q    <= items.element;
						last_q <= items.last;
						idx_q  <= '0;
						if (count_q < CNT_W'(MAX_ELEMS)) begin
							state_q <= T_X;
						end else begin
							overflow_q <= 1'b1;
							state_q    <= items.last ? T_SCAN : T_IDLE;
						end
					end
				end
				T_X: begin
					if (map_acc) begin
						state_q <= (count_q == '0) ? T_DBL : T_SUM;
					end
				end
				T_SUM: begin
					if (map_acc) begin
						state_q <= T_DIF;
					end
				end
				T_DIF: begin
					if (map_acc) begin
						idx_q   <= idx_inc;
						state_q <= (idx_inc == count_q) ? T_DBL : T_SUM;
					end
				end
				T_DBL: begin
					if (map_acc) begin
						state_q <= T_ZERO;
					end
				end
				T_ZERO: begin
					if (map_acc) begin
						count_q <= count_q + CNT_W'(1);
						idx_q   <= '0;
						state_q <= last_q ? T_SCAN : T_IDLE;
					end
				end
				T_SCAN: begin
					if (map_acc) begin
						state_q <= T_WAIT;
					end
				end
				T_WAIT: begin
					if (map_rsp.done) begin
						out_valid_q <= 1'b1;
						score_q     <= map_rsp.score;
						ovf_out_q   <= overflow_q;
						count_q     <= '0;
						idx_q       <= '0;
						overflow_q  <= 1'b0;
						state_q     <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign items.ready        = (state_q == T_IDLE);
	assign results.valid      = out_valid_q;
	assign results.score      = score_q;
	assign results.overflowed = ovf_out_q;

	`ASSERT_IMPLIES(a_done_only_waiting, clk, arst_n, map_rsp.done, state_q == T_WAIT)
	`ASSERT_IMPLIES(a_store_has_room, clk, arst_n, st_we, count_q < CNT_W'(MAX_ELEMS))
	`ASSERT_NEXT(a_full_sets_overflow, clk, arst_n, in_acc && count_q == CNT_W'(MAX_ELEMS), overflow_q)

endmodule

/* tb/sv/sum_difference_coverage_scorer_test.sv */
// testbench for the sum/difference coverage scorer: queued sets, self-predicting score check
`timescale 1ns / 1ps

module sum_difference_coverage_scorer_test;
	import sdcs_pkg::*;

	localparam int MAP_BITS    = MAP_WORDS_DEF * WORD_W;
	localparam int HOLD_AT     = 12;
	localparam int HOLD_CYCLES = 4000;
	localparam int SETTLE      = 1200;
	localparam int ITEM_TARGET = 450;

	typedef struct {
		logic signed [ELEM_W-1:0] element;
		logic                     last;
		bit                       drain;
	} elem_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               overflowed;
	} score_t;

	logic clk;
	logic arst_n;

	sdcs_in_if  items_ch ();
	sdcs_out_if results_ch ();

	sum_difference_coverage_scorer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch)
	);

	elem_item_t pending[$];
	score_t     scores_due[$];

	// shadow state of the scorer
	bit cov_map [0:MAP_BITS-1];
	int set_elems [0:MAX_ELEMS_DEF-1];
	int set_size;
	bit set_dropped;

	int errors;
	int elems_taken;
	int scores_taken;
	bit offering;

	always #5 clk = ~clk;

	function automatic void mark_value(int v);
		if (v >= 0 && v < MAP_BITS)
			cov_map[v] = 1'b1;
	endfunction

	function automatic logic [SCORE_W-1:0] covered_run();
		int m;
		m = 0;
		for (int k = 1; k < MAP_BITS; k++) begin
			if (!cov_map[k])
				break;
			m++;
		end
		return (m > int'(SCORE_MAX)) ? SCORE_MAX : m[SCORE_W-1:0];
	endfunction

	function automatic void take_element(logic signed [ELEM_W-1:0] x, logic last);
		int xv;
		score_t s;
		xv = x;
		if (set_size < MAX_ELEMS_DEF) begin
			mark_value(xv);
			for (int i = 0; i < set_size; i++) begin
				mark_value(xv + set_elems[i]);
				mark_value(xv - set_elems[i]);
			end
			mark_value(xv + xv);
			mark_value(0);
			set_elems[set_size] = xv;
			set_size++;
		end else begin
			set_dropped = 1'b1;
		end
		if (last) begin
			s.score = covered_run();
			s.overflowed = set_dropped;
			scores_due.push_back(s);
			cov_map = '{default: 1'b0};
			set_size = 0;
			set_dropped = 1'b0;
		end
	endfunction

	function automatic void add_elem(int v, bit last, bit drain = 1'b0);
		elem_item_t it;
		it.element = v[ELEM_W-1:0];
		it.last = last;
		it.drain = drain;
		pending.push_back(it);
	endfunction

	function automatic int random_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return int'($urandom_range(0, 170)) - 20;
		else if (r < 85)
			return $urandom_range(0, 300);
		else
			return $urandom_range(0, 65535);
	endfunction

	function automatic int draw_wait(int n);
		// every third block of 32 transfers runs without idling
		if ((n / 32) % 3 == 0)
			return 0;
		return $urandom_range(0, 4);
	endfunction

	// input transfers feed the predictor
	always @(posedge clk) begin
		if (arst_n && items_ch.valid && items_ch.ready) begin
			take_element(items_ch.element, items_ch.last);
			elems_taken++;
		end
	end

	// result transfers are checked against the oldest prediction
	always @(posedge clk) begin
		score_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			scores_taken++;
			if (scores_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got score %0d overflowed %0b",
					$time, results_ch.score, results_ch.overflowed);
				errors++;
			end else begin
				want = scores_due.pop_front();
				if (results_ch.score !== want.score) begin
					$display("%0t: score mismatch, expected %0d, got %0d",
						$time, want.score, results_ch.score);
					errors++;
				end
				if (results_ch.overflowed !== want.overflowed) begin
					$display("%0t: overflowed mismatch, expected %0b, got %0b",
						$time, want.overflowed, results_ch.overflowed);
					errors++;
				end
			end
		end
	end

	// driver
	int offered;
	int src_wait;
	elem_item_t cur;

	always @(negedge clk) begin
		if (arst_n) begin
			if (offering && elems_taken == offered) begin
				offering = 1'b0;
				src_wait = draw_wait(elems_taken);
			end
			if (!offering) begin
				if (src_wait > 0) begin
					src_wait--;
				end else if (pending.size() > 0 &&
						!(pending[0].drain && scores_due.size() != 0)) begin
					cur = pending.pop_front();
					offering = 1'b1;
					offered++;
				end
			end
			items_ch.valid   <= offering;
			items_ch.element <= cur.element;
			items_ch.last    <= cur.last;
		end
	end

	// result side ready, with one long hold-off so the block backs up
	int seen_scores;
	int sink_wait;
	int hold_left;
	bit hold_done;

	always @(negedge clk) begin
		if (arst_n) begin
			if (scores_taken != seen_scores) begin
				seen_scores = scores_taken;
				sink_wait = draw_wait(scores_taken);
				if (scores_taken == HOLD_AT && !hold_done) begin
					hold_left = HOLD_CYCLES;
					hold_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int n_items;
		int set_no;
		int len;
		int r;
		clk = 1'b0;
		arst_n = 1'b0;
		items_ch.valid = 1'b0;
		items_ch.element = '0;
		items_ch.last = 1'b0;
		results_ch.ready = 1'b0;
		cur.element = '0;
		cur.last = 1'b0;
		cur.drain = 1'b0;
		errors = 0;
		set_size = 0;
		set_dropped = 1'b0;
		cov_map = '{default: 1'b0};

		// directed sets
		add_elem(0, 1);
		add_elem(1, 1);
		add_elem(32767, 0, 1);
		add_elem(-32768, 1);
		add_elem(-1, 0);
		add_elem(-5, 0);
		add_elem(3, 1);
		add_elem(1, 0);
		add_elem(3, 0);
		add_elem(7, 0);
		add_elem(12, 0);
		add_elem(20, 1);
		// equal extremes: zero difference, sums off the map
		add_elem(32767, 0);
		add_elem(32767, 0);
		add_elem(-32768, 0);
		add_elem(-32768, 1);
		add_elem(2, 0);
		add_elem(-2, 0);
		add_elem(0, 1);
		add_elem(21845, 0);
		add_elem(-21846, 1);
		n_items = pending.size();

		// random sets, two of them past capacity with last on a dropped element
		set_no = 0;
		while (n_items < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (set_no == 8 || set_no == 30)
				len = MAX_ELEMS_DEF + 1 + $urandom_range(0, 2);
			else if (r < 70)
				len = $urandom_range(1, 8);
			else
				len = $urandom_range(9, 30);
			for (int i = 0; i < len; i++)
				add_elem(random_value(), i == len - 1,
					i == 0 && (set_no == 9 || $urandom_range(0, 19) == 0));
			n_items += len;
			set_no++;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending.size() == 0 && !offering);
		wait (scores_due.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("simulation failed");
		$finish;
	end

endmodule
